@@ rtl/core/wspe_pkg.sv @@
`timescale 1ns / 1ps
package wspe_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 31;

    localparam logic [REG_IDX_W-1:0] REG_PROP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OBS1  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OBS2  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PLANT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FRIC  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INERT = 3'd7;

    localparam logic signed [31:0] ZERO_BAND = 32'sd655;
    localparam logic signed [31:0] INTEG_MAX = 32'sd327680;
    localparam logic signed [31:0] DRIVE_MAX = 32'sd786432;
    localparam logic [30:0] FILT_NEW = 31'd45875;
    localparam logic [30:0] FILT_OLD = 31'd19661;

    // sequencer steps, one shared multiply each where a product is needed
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FRIC,
        ST_INERT,
        ST_FILT_N,
        ST_FILT_O,
        ST_PID_P,
        ST_PID_I,
        ST_PID_D,
        ST_DRIVE,
        ST_OBS_B,
        ST_OBS_E,
        ST_OBS_D,
        ST_OBS_U,
        ST_OUT
    } seq_state_t;

    // request to the shared multiplier
    typedef struct packed {
        logic [30:0]        coef;
        logic signed [31:0] value;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [63:0] clampsym(input logic signed [63:0] x,
                                                    input logic signed [31:0] lim);
        logic signed [63:0] l;
        l = 64'(lim);
        if (x > l)
            return l;
        else if (x < -l)
            return -l;
        else
            return x;
    endfunction

endpackage

@@ rtl/core/wspe_mul.sv @@
`timescale 1ns / 1ps
// Shared multiplier: unsigned 31-bit coefficient by signed 32-bit value,
// registered, full exact product; the caller applies the Q16.16 floor shift.
module wspe_mul (
    input  logic                     clk,
    input  wspe_pkg::mul_req_t       req,
    output logic signed [63:0]       prod
);
    import wspe_pkg::*;

    logic signed [63:0] full;

    assign full = $signed({1'b0, req.coef}) * req.value;

    // register the product
    always_ff @(posedge clk)
    begin
        prod <= full;
    end
endmodule

@@ rtl/core/wheel_speed_pid_eso_controller.sv @@
`timescale 1ns / 1ps
// Wheel speed controller: target clamp and slew limit, friction and inertia
// feedforward, PID with filtered derivative, and a second-order extended state
// observer, all in signed Q16.16. For each request a sequencer walks ten
// products through a single registered 31x32 multiplier, then the result
// moves into an output register. in_stall is high while the sequencer runs,
// so a new request is accepted only once the last one has finished; a result
// still waiting in the output register holds the sequencer in its last step
// until the register frees up.
// Registers may be written only while no request is in flight.
module wheel_speed_pid_eso_controller #(
    parameter int DT_SHIFT    = 10,
    parameter int SPEED_LIMIT = 1310720,
    parameter int STEP_LIMIT  = 3277
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                target_speed,
    input  logic signed [31:0]                measured_speed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                drive_value,
    input  logic                              cfg_we,
    input  logic [wspe_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [wspe_pkg::CFG_W-1:0]        cfg_data
);
    import wspe_pkg::*;

    localparam logic signed [63:0] STP_LIM = 64'(STEP_LIMIT);

    logic [CFG_W-1:0] regs_reg [REG_COUNT];

    seq_state_t state_reg, state_next;
    logic signed [31:0] integ_reg, lerr_reg, lfilt_reg, ltgt_reg, sest_reg, dest_reg;
    logic signed [31:0] w_reg, meas_reg, err_reg, raw_reg, derr_reg, u_reg;
    logic signed [63:0] acc_reg, facc_reg;
    logic               out_valid_reg;
    logic signed [31:0] drive_reg;
    logic               out_free;

    mul_req_t           req;
    logic signed [63:0] prod;

    logic signed [63:0] tgt_c, dlt, wl, tmp, pscl;
    logic signed [31:0] err_n;

    wspe_mul u_mul (
        .clk  (clk),
        .req  (req),
        .prod (prod)
    );

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[0] <= 31'd196608;
            regs_reg[1] <= 31'd655360;
            regs_reg[2] <= 31'd3277;
            regs_reg[3] <= 31'd3276800;
            regs_reg[4] <= 31'd98304000;
            regs_reg[5] <= 31'd65536;
            regs_reg[6] <= 31'd0;
            regs_reg[7] <= 31'd0;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // output register is free when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;

    // advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_FRIC;
            ST_FRIC:   state_next = ST_INERT;
            ST_INERT:  state_next = ST_FILT_N;
            ST_FILT_N: state_next = ST_FILT_O;
            ST_FILT_O: state_next = ST_PID_P;
            ST_PID_P:  state_next = ST_PID_I;
            ST_PID_I:  state_next = ST_PID_D;
            ST_PID_D:  state_next = ST_DRIVE;
            ST_DRIVE:  state_next = ST_OBS_B;
            ST_OBS_B:  state_next = ST_OBS_E;
            ST_OBS_E:  state_next = ST_OBS_D;
            ST_OBS_D:  state_next = ST_OBS_U;
            ST_OBS_U:  state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

    // load the result when the output register is free, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
            drive_reg     <= u_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // pick the multiplier operands for each step; product lands next step
    always_comb
    begin
        req.coef  = regs_reg[REG_FRIC];
        req.value = w_reg;
        unique case (state_reg)
            ST_FRIC:   begin req.coef = regs_reg[REG_FRIC];  req.value = w_reg;     end
            ST_INERT:  begin req.coef = regs_reg[REG_INERT]; req.value = derr_reg;  end
            ST_FILT_N: begin req.coef = FILT_NEW;            req.value = raw_reg;   end
            ST_FILT_O: begin req.coef = FILT_OLD;            req.value = lfilt_reg; end
            ST_PID_P:  begin req.coef = regs_reg[REG_PROP];  req.value = err_reg;   end
            ST_PID_I:  begin req.coef = regs_reg[REG_INTEG]; req.value = integ_reg; end
            ST_PID_D:  begin req.coef = regs_reg[REG_DERIV]; req.value = lfilt_reg; end
            ST_OBS_B:  begin req.coef = regs_reg[REG_PLANT]; req.value = u_reg;     end
            ST_OBS_E:  begin req.coef = regs_reg[REG_OBS1];  req.value = err_reg;   end
            ST_OBS_D:  begin req.coef = regs_reg[REG_OBS2];  req.value = err_reg;   end
            default:   begin req.coef = regs_reg[REG_FRIC];  req.value = w_reg;     end
        endcase
    end

    // datapath; the two filter products are summed exactly and floored once
    always_comb
    begin
        tgt_c = clampsym(64'(target_speed), 32'(SPEED_LIMIT));
        dlt   = tgt_c - 64'(ltgt_reg);
        wl    = tgt_c;
        if (dlt > STP_LIM)  wl = 64'(ltgt_reg) + STP_LIM;
        if (dlt < -STP_LIM) wl = 64'(ltgt_reg) - STP_LIM;
        err_n = sat32(64'(w_reg) - 64'(meas_reg));
        tmp   = 64'(err_n) - 64'(lerr_reg);
        pscl  = prod >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            lerr_reg  <= '0;
            lfilt_reg <= '0;
            ltgt_reg  <= '0;
            sest_reg  <= '0;
            dest_reg  <= '0;
            w_reg     <= '0;
            meas_reg  <= '0;
            err_reg   <= '0;
            raw_reg   <= '0;
            derr_reg  <= '0;
            u_reg     <= '0;
            acc_reg   <= '0;
            facc_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        w_reg    <= sat32(wl);
                        meas_reg <= measured_speed;
                        derr_reg <= sat32(64'(sat32(sat32(wl) - 64'(ltgt_reg)))
                                          <<< DT_SHIFT);
                        ltgt_reg <= sat32(wl);
                    end
                end
                ST_PREP:
                begin
                    err_reg  <= err_n;
                    if (w_reg < ZERO_BAND && w_reg > -ZERO_BAND)
                        integ_reg <= 32'(clampsym(64'(err_n >>> DT_SHIFT), INTEG_MAX));
                    else
                        integ_reg <= 32'(clampsym(64'(integ_reg) + 64'(err_n >>> DT_SHIFT),
                                                  INTEG_MAX));
                    raw_reg  <= sat32(tmp <<< DT_SHIFT);
                    lerr_reg <= err_n;
                end
                ST_FRIC:   ;
                ST_INERT:  acc_reg <= pscl;
                ST_FILT_N: acc_reg <= acc_reg + pscl;
                ST_FILT_O: facc_reg <= prod;
                ST_PID_P:  lfilt_reg <= 32'((facc_reg + prod) >>> 16);
                ST_PID_I:  acc_reg <= acc_reg + pscl;
                ST_PID_D:  acc_reg <= acc_reg + pscl;
                ST_DRIVE:
                begin
                    u_reg   <= sat32(clampsym(acc_reg + pscl, DRIVE_MAX)
                                     - 64'(dest_reg));
                    err_reg <= sat32(64'(meas_reg) - 64'(sest_reg));
                end
                ST_OBS_B:  ;
                ST_OBS_E:  acc_reg <= 64'(dest_reg) + pscl;
                ST_OBS_D:
                begin
                    sest_reg <= sat32(64'(sest_reg) + ((acc_reg - pscl) >>> DT_SHIFT));
                end
                ST_OBS_U:
                begin
                    dest_reg <= sat32(64'(dest_reg) + (((-prod) >>> 16) >>> DT_SHIFT));
                end
                ST_OUT:    ;
                default:   ;
            endcase
        end
    end
endmodule

@@ rtl/core/wspe_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the wheel speed controller.
module wspe_port_checks (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic signed [31:0] drive_value
);
    // a request accepted keeps the block busy for the whole sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall [*14])
        else $error("not busy after request");

    // handshake outputs always known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive_value)))
        else $error("stalled result changed");

    // the result only changes when a new one is presented
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(drive_value) |-> out_valid)
        else $error("result changed without valid");
endmodule

bind wheel_speed_pid_eso_controller wspe_port_checks u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_value (drive_value)
);
